>>> rtl/core/ll1_predictive_parser_unit_macros.svh
// assertion macros for the ll1 predictive parser checker
// relies on clk and rst being visible in the scope that expands them
`ifndef LL1_PREDICTIVE_PARSER_UNIT_MACROS_SVH
`define LL1_PREDICTIVE_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define LLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/llp_pkg.sv
// llp_pkg: symbol codes, status codes and grammar tables for the ll1 parser
// no dependencies; used by the parser core and its checker
`timescale 1ns / 1ps
`default_nettype none

package llp_pkg;

  localparam int TOKEN_W  = 5;
  localparam int STATUS_W = 3;
  localparam int EXPS_W   = 6;
  localparam int SYM_W    = 6;
  localparam int PROD_W   = 5;
  localparam int LEN_W    = 3;
  localparam int BODY_MAX = 7;

  localparam logic [EXPS_W-1:0] EXPS_MAX = 6'd63;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_MATCH    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_ACCEPT   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;

  // terminals
  localparam logic [TOKEN_W-1:0] T_EOF    = 5'd0;
  localparam logic [TOKEN_W-1:0] T_INT    = 5'd1;
  localparam logic [TOKEN_W-1:0] T_FLT    = 5'd2;
  localparam logic [TOKEN_W-1:0] T_IF     = 5'd3;
  localparam logic [TOKEN_W-1:0] T_ELSE   = 5'd4;
  localparam logic [TOKEN_W-1:0] T_WHILE  = 5'd5;
  localparam logic [TOKEN_W-1:0] T_SEMI   = 5'd6;
  localparam logic [TOKEN_W-1:0] T_COMMA  = 5'd7;
  localparam logic [TOKEN_W-1:0] T_ASSIGN = 5'd8;
  localparam logic [TOKEN_W-1:0] T_PLUS   = 5'd9;
  localparam logic [TOKEN_W-1:0] T_MINUS  = 5'd10;
  localparam logic [TOKEN_W-1:0] T_STAR   = 5'd11;
  localparam logic [TOKEN_W-1:0] T_SLASH  = 5'd12;
  localparam logic [TOKEN_W-1:0] T_LP     = 5'd13;
  localparam logic [TOKEN_W-1:0] T_RP     = 5'd14;
  localparam logic [TOKEN_W-1:0] T_ID     = 5'd15;
  localparam logic [TOKEN_W-1:0] T_NUM    = 5'd16;

  // nonterminals, top bit set
  localparam logic [SYM_W-1:0] N_PROG   = 6'd32;
  localparam logic [SYM_W-1:0] N_DECLS  = 6'd33;
  localparam logic [SYM_W-1:0] N_DECLS2 = 6'd34;
  localparam logic [SYM_W-1:0] N_DECL   = 6'd35;
  localparam logic [SYM_W-1:0] N_TYPE   = 6'd36;
  localparam logic [SYM_W-1:0] N_VARS   = 6'd37;
  localparam logic [SYM_W-1:0] N_VARS2  = 6'd38;
  localparam logic [SYM_W-1:0] N_STMTS  = 6'd39;
  localparam logic [SYM_W-1:0] N_STMTS2 = 6'd40;
  localparam logic [SYM_W-1:0] N_STMT   = 6'd41;
  localparam logic [SYM_W-1:0] N_EXPR   = 6'd42;
  localparam logic [SYM_W-1:0] N_EXPR2  = 6'd43;
  localparam logic [SYM_W-1:0] N_TERM   = 6'd44;
  localparam logic [SYM_W-1:0] N_TERM2  = 6'd45;
  localparam logic [SYM_W-1:0] N_FACT   = 6'd46;

  // productions
  localparam logic [PROD_W-1:0] P_NONE        = 5'd0;
  localparam logic [PROD_W-1:0] P_PROG        = 5'd1;
  localparam logic [PROD_W-1:0] P_DECLS       = 5'd2;
  localparam logic [PROD_W-1:0] P_DECLS2_MORE = 5'd3;
  localparam logic [PROD_W-1:0] P_DECLS2_EPS  = 5'd4;
  localparam logic [PROD_W-1:0] P_DECL        = 5'd5;
  localparam logic [PROD_W-1:0] P_TYPE_INT    = 5'd6;
  localparam logic [PROD_W-1:0] P_TYPE_FLT    = 5'd7;
  localparam logic [PROD_W-1:0] P_VARS        = 5'd8;
  localparam logic [PROD_W-1:0] P_VARS2_MORE  = 5'd9;
  localparam logic [PROD_W-1:0] P_VARS2_EPS   = 5'd10;
  localparam logic [PROD_W-1:0] P_STMTS       = 5'd11;
  localparam logic [PROD_W-1:0] P_STMTS2_MORE = 5'd12;
  localparam logic [PROD_W-1:0] P_STMTS2_EPS  = 5'd13;
  localparam logic [PROD_W-1:0] P_ASSIGN      = 5'd14;
  localparam logic [PROD_W-1:0] P_IF          = 5'd15;
  localparam logic [PROD_W-1:0] P_WHILE       = 5'd16;
  localparam logic [PROD_W-1:0] P_EXPR        = 5'd17;
  localparam logic [PROD_W-1:0] P_EXPR2_ADD   = 5'd18;
  localparam logic [PROD_W-1:0] P_EXPR2_SUB   = 5'd19;
  localparam logic [PROD_W-1:0] P_EXPR2_EPS   = 5'd20;
  localparam logic [PROD_W-1:0] P_TERM        = 5'd21;
  localparam logic [PROD_W-1:0] P_TERM2_MUL   = 5'd22;
  localparam logic [PROD_W-1:0] P_TERM2_DIV   = 5'd23;
  localparam logic [PROD_W-1:0] P_TERM2_EPS   = 5'd24;
  localparam logic [PROD_W-1:0] P_FACT_PAR    = 5'd25;
  localparam logic [PROD_W-1:0] P_FACT_ID     = 5'd26;
  localparam logic [PROD_W-1:0] P_FACT_NUM    = 5'd27;

  typedef logic [BODY_MAX-1:0][SYM_W-1:0] body_t;

  // predict table; terminals and unknown codes give no entry
  function automatic logic [PROD_W-1:0] llp_predict(input logic [SYM_W-1:0] sym,
                                                    input logic [TOKEN_W-1:0] tok);
    logic [PROD_W-1:0] p;
    p = P_NONE;
    case (sym)
      N_PROG:   if (tok == T_INT || tok == T_FLT) p = P_PROG;
      N_DECLS:  if (tok == T_INT || tok == T_FLT) p = P_DECLS;
      N_DECLS2: begin
        case (tok) inside
          T_INT, T_FLT:        p = P_DECLS2_MORE;
          T_IF, T_WHILE, T_ID: p = P_DECLS2_EPS;
          default:             p = P_NONE;
        endcase
      end
      N_DECL:   if (tok == T_INT || tok == T_FLT) p = P_DECL;
      N_TYPE: begin
        case (tok)
          T_INT:   p = P_TYPE_INT;
          T_FLT:   p = P_TYPE_FLT;
          default: p = P_NONE;
        endcase
      end
      N_VARS:   if (tok == T_ID) p = P_VARS;
      N_VARS2: begin
        case (tok)
          T_SEMI:  p = P_VARS2_EPS;
          T_COMMA: p = P_VARS2_MORE;
          default: p = P_NONE;
        endcase
      end
      N_STMTS:  if (tok == T_IF || tok == T_WHILE || tok == T_ID) p = P_STMTS;
      N_STMTS2: begin
        case (tok) inside
          T_EOF, T_ELSE:       p = P_STMTS2_EPS;
          T_IF, T_WHILE, T_ID: p = P_STMTS2_MORE;
          default:             p = P_NONE;
        endcase
      end
      N_STMT: begin
        case (tok)
          T_IF:    p = P_IF;
          T_WHILE: p = P_WHILE;
          T_ID:    p = P_ASSIGN;
          default: p = P_NONE;
        endcase
      end
      N_EXPR:   if (tok == T_LP || tok == T_ID || tok == T_NUM) p = P_EXPR;
      N_EXPR2: begin
        case (tok) inside
          T_SEMI, T_RP: p = P_EXPR2_EPS;
          T_PLUS:       p = P_EXPR2_ADD;
          T_MINUS:      p = P_EXPR2_SUB;
          default:      p = P_NONE;
        endcase
      end
      N_TERM:   if (tok == T_LP || tok == T_ID || tok == T_NUM) p = P_TERM;
      N_TERM2: begin
        case (tok) inside
          T_SEMI, T_PLUS, T_MINUS, T_RP: p = P_TERM2_EPS;
          T_STAR:                        p = P_TERM2_MUL;
          T_SLASH:                       p = P_TERM2_DIV;
          default:                       p = P_NONE;
        endcase
      end
      N_FACT: begin
        case (tok)
          T_LP:    p = P_FACT_PAR;
          T_ID:    p = P_FACT_ID;
          T_NUM:   p = P_FACT_NUM;
          default: p = P_NONE;
        endcase
      end
      default: p = P_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] llp_body_len(input logic [PROD_W-1:0] prod);
    logic [LEN_W-1:0] n;
    case (prod) inside
      P_PROG, P_DECLS, P_DECLS2_MORE, P_VARS, P_STMTS, P_STMTS2_MORE,
      P_EXPR, P_TERM:                                    n = 3'd2;
      P_DECL, P_VARS2_MORE, P_EXPR2_ADD, P_EXPR2_SUB,
      P_TERM2_MUL, P_TERM2_DIV, P_FACT_PAR:              n = 3'd3;
      P_TYPE_INT, P_TYPE_FLT, P_FACT_ID, P_FACT_NUM:     n = 3'd1;
      P_ASSIGN:                                          n = 3'd4;
      P_IF:                                              n = 3'd7;
      P_WHILE:                                           n = 3'd5;
      default:                                           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic body_t llp_body(input logic [PROD_W-1:0] prod);
    body_t b;
    b = '0;
    case (prod)
      P_PROG: begin
        b[0] = N_DECLS;  b[1] = N_STMTS;
      end
      P_DECLS, P_DECLS2_MORE: begin
        b[0] = N_DECL;   b[1] = N_DECLS2;
      end
      P_DECL: begin
        b[0] = N_TYPE;   b[1] = N_VARS;    b[2] = {1'b0, T_SEMI};
      end
      P_TYPE_INT: b[0] = {1'b0, T_INT};
      P_TYPE_FLT: b[0] = {1'b0, T_FLT};
      P_VARS: begin
        b[0] = {1'b0, T_ID};    b[1] = N_VARS2;
      end
      P_VARS2_MORE: begin
        b[0] = {1'b0, T_COMMA}; b[1] = {1'b0, T_ID}; b[2] = N_VARS2;
      end
      P_STMTS, P_STMTS2_MORE: begin
        b[0] = N_STMT;   b[1] = N_STMTS2;
      end
      P_ASSIGN: begin
        b[0] = {1'b0, T_ID}; b[1] = {1'b0, T_ASSIGN}; b[2] = N_EXPR; b[3] = {1'b0, T_SEMI};
      end
      P_IF: begin
        b[0] = {1'b0, T_IF};   b[1] = {1'b0, T_LP}; b[2] = N_EXPR; b[3] = {1'b0, T_RP};
        b[4] = N_STMTS;        b[5] = {1'b0, T_ELSE}; b[6] = N_STMTS;
      end
      P_WHILE: begin
        b[0] = {1'b0, T_WHILE}; b[1] = {1'b0, T_LP}; b[2] = N_EXPR; b[3] = {1'b0, T_RP};
        b[4] = N_STMTS;
      end
      P_EXPR: begin
        b[0] = N_TERM;   b[1] = N_EXPR2;
      end
      P_EXPR2_ADD: begin
        b[0] = {1'b0, T_PLUS};  b[1] = N_TERM; b[2] = N_EXPR2;
      end
      P_EXPR2_SUB: begin
        b[0] = {1'b0, T_MINUS}; b[1] = N_TERM; b[2] = N_EXPR2;
      end
      P_TERM: begin
        b[0] = N_FACT;   b[1] = N_TERM2;
      end
      P_TERM2_MUL: begin
        b[0] = {1'b0, T_STAR};  b[1] = N_FACT; b[2] = N_TERM2;
      end
      P_TERM2_DIV: begin
        b[0] = {1'b0, T_SLASH}; b[1] = N_FACT; b[2] = N_TERM2;
      end
      P_FACT_PAR: begin
        b[0] = {1'b0, T_LP};    b[1] = N_EXPR; b[2] = {1'b0, T_RP};
      end
      P_FACT_ID:  b[0] = {1'b0, T_ID};
      P_FACT_NUM: b[0] = {1'b0, T_NUM};
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ll1_predictive_parser_unit.sv
// ll1_predictive_parser_unit: table-driven ll(1) parser, one token per input word
// depends on llp_pkg for symbol codes and the predict and production tables
`timescale 1ns / 1ps
`default_nettype none

// Takes one token per input word and returns one result word with the parse status and
// the number of productions applied for it. The symbol stack lives in a memory with
// separate read and write ports, and the sequencer does one stack access per cycle:
// a pop is a read state, then an evaluate state against the predict table, and each
// pushed symbol is a push state. A fresh parse first reloads the stack with the end
// marker and start symbol; the next token is taken only once the current one is done.
// The input is stalled while a token is being worked on; a finished result waits in
// the output register while the next token is accepted. After accept or any error the
// next token starts a new parse.
module ll1_predictive_parser_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [llp_pkg::TOKEN_W-1:0]   token_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [llp_pkg::STATUS_W-1:0]  status,
  output logic [llp_pkg::EXPS_W-1:0]    expansions
);
  import llp_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_READ = 6'b000100,
    ST_EVAL = 6'b001000,
    ST_PUSH = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t               state;
  logic                 fresh;
  logic [TOP_W-1:0]     top;
  logic [TOKEN_W-1:0]   tok;
  logic [EXPS_W-1:0]    exps;
  logic [STATUS_W-1:0]  outcome;
  logic [PROD_W-1:0]    prod;
  logic [LEN_W-1:0]     push_left;

  logic [SYM_W-1:0]     stack_mem [STACK_DEPTH];
  logic [SYM_W-1:0]     rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SYM_W-1:0]     wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  logic                 in_take;
  logic                 out_free;
  logic [PROD_W-1:0]    prod_sel;
  logic [LEN_W-1:0]     len_sel;
  logic                 fits;
  logic [TOP_W-1:0]     top_dec;
  body_t                body;
  logic [LEN_W-1:0]     body_idx;

  assign in_stall = rst || (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign prod_sel = llp_predict(rd_data, tok);
  assign len_sel  = llp_body_len(prod_sel);
  assign fits     = ({1'b0, top} + (TOP_W + 1)'(len_sel)) <= (TOP_W + 1)'(STACK_DEPTH);
  assign top_dec  = top - 1'b1;
  assign body     = llp_body(prod);
  assign body_idx = push_left - 1'b1;

  // stack port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = top_dec[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        wr_en   = in_take && fresh;
        wr_data = {1'b0, T_EOF};
      end
      ST_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = AW'(1);
        wr_data = N_PROG;
      end
      ST_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = top[AW-1:0];
        wr_data = body[body_idx];
      end
      ST_READ: rd_en = (top != '0);
      ST_EVAL, ST_DONE: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fresh     <= 1'b1;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            tok   <= token_code;
            exps  <= '0;
            state <= fresh ? ST_LOAD : ST_READ;
          end
        end
        ST_LOAD: begin
          top   <= TOP_W'(2);
          fresh <= 1'b0;
          state <= ST_READ;
        end
        ST_READ: begin
          if (top == '0) begin
            outcome <= STATUS_NO_ENTRY;
            state   <= ST_DONE;
          end else begin
            top   <= top_dec;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!rd_data[SYM_W-1]) begin
            if (rd_data[TOKEN_W-1:0] != tok) begin
              outcome <= STATUS_MISMATCH;
            end else if (tok == T_EOF) begin
              outcome <= STATUS_ACCEPT;
            end else begin
              outcome <= STATUS_MATCH;
            end
            state <= ST_DONE;
          end else if (prod_sel == P_NONE) begin
            outcome <= STATUS_NO_ENTRY;
            state   <= ST_DONE;
          end else begin
            if (exps != EXPS_MAX) begin
              exps <= exps + 1'b1;
            end
            if (!fits) begin
              outcome <= STATUS_OVERFLOW;
              state   <= ST_DONE;
            end else begin
              prod      <= prod_sel;
              push_left <= len_sel;
              state     <= (len_sel == '0) ? ST_READ : ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          top       <= top + 1'b1;
          push_left <= body_idx;
          if (push_left == LEN_W'(1)) begin
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            status     <= outcome;
            expansions <= exps;
            if (outcome != STATUS_MATCH) begin
              fresh <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/llp_checker.sv
// llp_checker: port-level assertions for the ll1 parser, bound to the top level
// depends on llp_pkg and ll1_predictive_parser_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ll1_predictive_parser_unit_macros.svh"

module llp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [llp_pkg::STATUS_W-1:0]  status,
  input logic [llp_pkg::EXPS_W-1:0]    expansions
);
  import llp_pkg::*;

  // one token at a time
  `LLP_ASSERT_NEXT(a_one_word_in_flight, in_valid && !in_stall, in_stall, "word taken while busy")

  `LLP_ASSERT_NOW(a_status_code, out_valid, status <= STATUS_OVERFLOW, "status code out of range")

  // overflow only arises while applying a production
  `LLP_ASSERT_NOW(a_overflow_counts, out_valid && status == STATUS_OVERFLOW,
                  expansions != '0, "overflow without an expansion")

  `LLP_ASSERT_NEXT(a_result_held, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(expansions), "stalled result changed")

endmodule

bind ll1_predictive_parser_unit llp_checker u_llp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .expansions (expansions)
);

`default_nettype wire

>>> dv/testbench.sv
// testbench for ll1_predictive_parser_unit: token words in, status and expansion count out
// keeps its own symbol stack and grammar rules to predict each result; needs llp_pkg
`timescale 1ns / 1ps

module testbench;
  import llp_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [TOKEN_W-1:0] TOKEN_CODE_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EXPS_W-1:0]   expansions;
  } parse_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [TOKEN_W-1:0]  token_code;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [EXPS_W-1:0]   expansions;

  parse_result_t      pending_results[$];
  logic [TOKEN_W-1:0] token_seq[$];
  logic [SYM_W-1:0]   shadow_stack[STACK_DEPTH];
  int                 shadow_top;
  bit                 shadow_fresh;
  int                 send_gap_pct;
  int                 stall_pct;
  int                 mismatches;
  int                 words_sent;
  int                 cycle_count;

  ll1_predictive_parser_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .token_code (token_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .expansions (expansions)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // production chosen for nonterminal nt under lookahead tok, body left to right
  function automatic bit grammar_rule(input logic [SYM_W-1:0] nt, input logic [TOKEN_W-1:0] tok,
                                      output int len, output logic [SYM_W-1:0] rhs [BODY_MAX]);
    bit type_tok, stmt_tok, fact_tok, found;
    type_tok = (tok == T_INT) || (tok == T_FLT);
    stmt_tok = (tok == T_IF) || (tok == T_WHILE) || (tok == T_ID);
    fact_tok = (tok == T_LP) || (tok == T_ID) || (tok == T_NUM);
    found = 1'b1;
    len = 0;
    rhs = '{default: '0};
    case (nt)
      N_PROG: if (type_tok) begin
        len = 2; rhs[0] = N_DECLS; rhs[1] = N_STMTS;
      end else found = 1'b0;
      N_DECLS: if (type_tok) begin
        len = 2; rhs[0] = N_DECL; rhs[1] = N_DECLS2;
      end else found = 1'b0;
      N_DECLS2: if (type_tok) begin
        len = 2; rhs[0] = N_DECL; rhs[1] = N_DECLS2;
      end else if (!stmt_tok) found = 1'b0;
      N_DECL: if (type_tok) begin
        len = 3; rhs[0] = N_TYPE; rhs[1] = N_VARS; rhs[2] = 6'(T_SEMI);
      end else found = 1'b0;
      N_TYPE: if (type_tok) begin
        len = 1; rhs[0] = 6'(tok);
      end else found = 1'b0;
      N_VARS: if (tok == T_ID) begin
        len = 2; rhs[0] = 6'(T_ID); rhs[1] = N_VARS2;
      end else found = 1'b0;
      N_VARS2: if (tok == T_COMMA) begin
        len = 3; rhs[0] = 6'(T_COMMA); rhs[1] = 6'(T_ID); rhs[2] = N_VARS2;
      end else if (tok != T_SEMI) found = 1'b0;
      N_STMTS: if (stmt_tok) begin
        len = 2; rhs[0] = N_STMT; rhs[1] = N_STMTS2;
      end else found = 1'b0;
      N_STMTS2: if (stmt_tok) begin
        len = 2; rhs[0] = N_STMT; rhs[1] = N_STMTS2;
      end else if (!((tok == T_EOF) || (tok == T_ELSE))) found = 1'b0;
      N_STMT: if (tok == T_ID) begin
        len = 4; rhs[0] = 6'(T_ID); rhs[1] = 6'(T_ASSIGN); rhs[2] = N_EXPR; rhs[3] = 6'(T_SEMI);
      end else if (tok == T_IF) begin
        len = 7; rhs[0] = 6'(T_IF); rhs[1] = 6'(T_LP); rhs[2] = N_EXPR; rhs[3] = 6'(T_RP);
        rhs[4] = N_STMTS; rhs[5] = 6'(T_ELSE); rhs[6] = N_STMTS;
      end else if (tok == T_WHILE) begin
        len = 5; rhs[0] = 6'(T_WHILE); rhs[1] = 6'(T_LP); rhs[2] = N_EXPR; rhs[3] = 6'(T_RP);
        rhs[4] = N_STMTS;
      end else found = 1'b0;
      N_EXPR: if (fact_tok) begin
        len = 2; rhs[0] = N_TERM; rhs[1] = N_EXPR2;
      end else found = 1'b0;
      N_EXPR2: if ((tok == T_PLUS) || (tok == T_MINUS)) begin
        len = 3; rhs[0] = 6'(tok); rhs[1] = N_TERM; rhs[2] = N_EXPR2;
      end else if (!((tok == T_SEMI) || (tok == T_RP))) found = 1'b0;
      N_TERM: if (fact_tok) begin
        len = 2; rhs[0] = N_FACT; rhs[1] = N_TERM2;
      end else found = 1'b0;
      N_TERM2: if ((tok == T_STAR) || (tok == T_SLASH)) begin
        len = 3; rhs[0] = 6'(tok); rhs[1] = N_FACT; rhs[2] = N_TERM2;
      end else if (!((tok == T_SEMI) || (tok == T_PLUS) || (tok == T_MINUS) || (tok == T_RP)))
        found = 1'b0;
      N_FACT: if (tok == T_LP) begin
        len = 3; rhs[0] = 6'(T_LP); rhs[1] = N_EXPR; rhs[2] = 6'(T_RP);
      end else if ((tok == T_ID) || (tok == T_NUM)) begin
        len = 1; rhs[0] = 6'(tok);
      end else found = 1'b0;
      default: found = 1'b0;
    endcase
    return found;
  endfunction

  // advances the shadow stack by one token and returns the expected result word
  function automatic parse_result_t predict_parse_step(input logic [TOKEN_W-1:0] tok);
    parse_result_t    res;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] rhs [BODY_MAX];
    int               len;
    bit               done;
    res.expansions = '0;
    res.status = STATUS_NO_ENTRY;
    done = 1'b0;
    if (shadow_fresh) begin
      shadow_stack[0] = 6'(T_EOF);
      shadow_stack[1] = N_PROG;
      shadow_top = 2;
      shadow_fresh = 1'b0;
    end
    while (!done) begin
      if ((shadow_top == 0) || (shadow_top > STACK_DEPTH)) begin
        res.status = STATUS_NO_ENTRY;
        done = 1'b1;
      end else begin
        shadow_top--;
        sym = shadow_stack[shadow_top];
        if (!sym[SYM_W-1]) begin
          if (sym[TOKEN_W-1:0] != tok) res.status = STATUS_MISMATCH;
          else if (tok == T_EOF) res.status = STATUS_ACCEPT;
          else res.status = STATUS_MATCH;
          done = 1'b1;
        end else if (!grammar_rule(sym, tok, len, rhs)) begin
          res.status = STATUS_NO_ENTRY;
          done = 1'b1;
        end else begin
          if (res.expansions != EXPS_MAX) res.expansions++;
          if (shadow_top + len > STACK_DEPTH) begin
            res.status = STATUS_OVERFLOW;
            done = 1'b1;
          end else begin
            for (int i = len - 1; i >= 0; i--) begin
              shadow_stack[shadow_top] = rhs[i];
              shadow_top++;
            end
          end
        end
      end
    end
    if (res.status != STATUS_MATCH) shadow_fresh = 1'b1;
    return res;
  endfunction

  // token sequence builders
  function automatic void gen_factor(input int depth);
    int pick;
    pick = $urandom_range(depth > 0 ? 2 : 1);
    if (pick == 0) token_seq.push_back(T_ID);
    else if (pick == 1) token_seq.push_back(T_NUM);
    else begin
      token_seq.push_back(T_LP);
      gen_expr(depth - 1);
      token_seq.push_back(T_RP);
    end
  endfunction

  function automatic void gen_term(input int depth);
    gen_factor(depth);
    repeat ($urandom_range(2)) begin
      token_seq.push_back($urandom_range(1) ? T_STAR : T_SLASH);
      gen_factor(depth);
    end
  endfunction

  function automatic void gen_expr(input int depth);
    gen_term(depth);
    repeat ($urandom_range(2)) begin
      token_seq.push_back($urandom_range(1) ? T_PLUS : T_MINUS);
      gen_term(depth);
    end
  endfunction

  function automatic void gen_stmts(input int depth);
    int pick;
    repeat (1 + $urandom_range(1)) begin
      pick = $urandom_range(depth > 0 ? 2 : 0);
      if (pick == 0) begin
        token_seq.push_back(T_ID);
        token_seq.push_back(T_ASSIGN);
        gen_expr(1);
        token_seq.push_back(T_SEMI);
      end else begin
        token_seq.push_back(pick == 1 ? T_IF : T_WHILE);
        token_seq.push_back(T_LP);
        gen_expr(1);
        token_seq.push_back(T_RP);
        gen_stmts(depth - 1);
        if (pick == 1) begin
          token_seq.push_back(T_ELSE);
          gen_stmts(depth - 1);
        end
      end
    end
  endfunction

  function automatic void gen_program();
    repeat (1 + $urandom_range(2)) begin
      token_seq.push_back($urandom_range(1) ? T_INT : T_FLT);
      token_seq.push_back(T_ID);
      repeat ($urandom_range(2)) begin
        token_seq.push_back(T_COMMA);
        token_seq.push_back(T_ID);
      end
      token_seq.push_back(T_SEMI);
    end
    gen_stmts(2);
    token_seq.push_back(T_EOF);
  endfunction

  task automatic send_word(input logic [TOKEN_W-1:0] tok);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    token_code <= tok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_parse_step(tok));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_sequence();
    foreach (token_seq[i]) send_word(token_seq[i]);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // declarations, while loop, nested brackets, epsilon rules and accept
  task automatic test_small_program();
    token_seq = '{T_FLT, T_ID, T_COMMA, T_ID, T_SEMI,
                  T_WHILE, T_LP, T_ID, T_STAR, T_LP, T_NUM, T_RP, T_RP,
                  T_ID, T_ASSIGN, T_ID, T_MINUS, T_ID, T_SEMI, T_EOF};
    send_sequence();
    wait_results_drained();
  endtask

  // unknown code, end marker on a fresh stack, wrong terminal, then a fresh parse
  task automatic test_error_recovery();
    token_seq = '{TOKEN_CODE_MAX, T_EOF, T_INT, T_ID, T_SEMI, T_ID, T_NUM, T_INT};
    send_sequence();
    wait_results_drained();
  endtask

  task automatic test_random_phase(input int gap, input int stall, input int n_words);
    int start_count;
    int pick;
    int pos;
    send_gap_pct = gap;
    stall_pct = stall;
    start_count = words_sent;
    while (words_sent - start_count < n_words) begin
      token_seq.delete();
      pick = $urandom_range(99);
      if (pick < 65) begin
        gen_program();
      end else if (pick < 85) begin
        gen_program();
        pos = $urandom_range(token_seq.size() - 1);
        token_seq[pos] = TOKEN_W'($urandom_range(TOKEN_CODE_MAX));
        token_seq = token_seq[0:pos];
      end else if (pick < 95) begin
        repeat (1 + $urandom_range(5))
          token_seq.push_back(TOKEN_W'($urandom_range(TOKEN_CODE_MAX)));
      end else begin
        // end marker forces a fresh parse, then deep brackets to push toward overflow
        token_seq = '{T_EOF, T_INT, T_ID, T_SEMI, T_ID, T_ASSIGN};
        repeat (18 + $urandom_range(6)) token_seq.push_back(T_LP);
        token_seq.push_back(T_ID);
      end
      send_sequence();
    end
    wait_results_drained();
  endtask

  task automatic flag_mismatch(input string what, input parse_result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s) at cycle %0d: expected status %0d expansions %0d, ",
                "got status %0d expansions %0d"},
               what, cycle_count, want.status, want.expansions, status, expansions);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        want = '0;
        flag_mismatch("no word expected", want);
      end else begin
        want = pending_results.pop_front();
        if ((status !== want.status) || (expansions !== want.expansions))
          flag_mismatch("result word", want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    token_code = '0;
    out_stall = 1'b0;
    send_gap_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    words_sent = 0;
    cycle_count = 0;
    shadow_top = 0;
    shadow_fresh = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_small_program();
    test_error_recovery();
    test_random_phase(0, 0, 125);
    test_random_phase(46, 0, 125);
    test_random_phase(0, 46, 125);
    test_random_phase(36, 36, 125);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
